// File: hw/rtl/hufd_pkg.sv
// Huffman tree decoder package: field widths, op codes and the structs
// passed between the walk sequencer, the symbol stage and the top level.
// No dependencies.
`default_nettype none

package hufd_pkg;

  localparam int IdxW  = 9;   // node_index
  localparam int HalfW = 16;  // one child index
  localparam int NodeW = 32;  // child_one in [31:16], child_zero in [15:0]
  localparam int WordW = 16;  // stream word
  localparam int PosW  = 4;   // bit position in a word
  localparam int CntW  = 5;   // bit count, 0..16
  localparam int SymW  = 8;

  localparam logic OpLoad = 1'b0;
  localparam logic OpFeed = 1'b1;

  // One accepted input item, decoded.
  typedef struct packed {
    logic             load;
    logic             feed;
    logic [IdxW-1:0]  node_index;
    logic             node_ok;      // node_index inside the tree memory
    logic [NodeW-1:0] node;
    logic             entry_start;
    logic [WordW-1:0] bits_word;
    logic [PosW-1:0]  first_bit;
    logic [CntW-1:0]  count;        // already clipped to the word end
  } cmd_t;

  // Walk sequencer to symbol stage.
  typedef struct packed {
    logic            sym_v;
    logic [SymW-1:0] sym;
    logic            done;          // item finished, flag the held symbol last
  } emit_t;

endpackage

`default_nettype wire

// File: hw/rtl/hufd_if.sv
// Valid/ready channel interfaces of the Huffman tree decoder.
// Depends on hufd_pkg for field widths.
`default_nettype none

interface hufd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [hufd_pkg::IdxW-1:0]   node_index;
  logic [hufd_pkg::HalfW-1:0]  child_zero;
  logic [hufd_pkg::HalfW-1:0]  child_one;
  logic [hufd_pkg::WordW-1:0]  bits_word;
  logic [hufd_pkg::PosW-1:0]   first_bit;
  logic [hufd_pkg::CntW-1:0]   bit_count;
  logic                        entry_start;

  modport source (
    output valid, op, node_index, child_zero, child_one, bits_word, first_bit,
           bit_count, entry_start,
    input  ready
  );
  modport sink (
    input  valid, op, node_index, child_zero, child_one, bits_word, first_bit,
           bit_count, entry_start,
    output ready
  );
endinterface

interface hufd_out_if;
  logic                       valid;
  logic                       ready;
  logic [hufd_pkg::SymW-1:0]  symbol;
  logic                       last;

  modport source (output valid, symbol, last, input ready);
  modport sink (input valid, symbol, last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hufd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module hufd_ram #(
  parameter int Width = 32,
  parameter int Depth = 512,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hufd_walk.sv
// Tree walk sequencer: one node memory read per stream bit, evaluates the
// returned node and issues the next read in the same cycle.
// Depends on hufd_pkg.
`default_nettype none

module hufd_walk #(
  parameter int TREE_DEPTH = 512,
  localparam int AddrW = $clog2(TREE_DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_valid_i,
  input  wire hufd_pkg::cmd_t              cmd_i,
  output logic                             ready_o,
  output logic                             rd_en_o,
  output logic [AddrW-1:0]                 rd_addr_o,
  input  wire logic [hufd_pkg::NodeW-1:0]  rd_data_i,
  input  wire logic                        emit_ready_i,
  output hufd_pkg::emit_t                  emit_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic                        state_q;
  logic [AddrW-1:0]            walk_q;
  logic [hufd_pkg::NodeW-1:0]  cur_q;    // contents of node walk_q
  logic [hufd_pkg::NodeW-1:0]  root_q;   // shadow of node 0
  logic                        pend_q;
  logic                        oob_q;
  logic [AddrW-1:0]            nidx_q;
  logic [hufd_pkg::WordW-1:0]  word_q;
  logic [hufd_pkg::PosW-1:0]   pos_q;
  logic [hufd_pkg::CntW-1:0]   left_q;

  logic [hufd_pkg::NodeW-1:0]  node;
  logic                        leaf;
  logic                        emit_wait;
  logic                        eval;
  logic [hufd_pkg::NodeW-1:0]  cur_d;
  logic [AddrW-1:0]            walk_d;
  logic                        bit_val;
  logic [hufd_pkg::HalfW-1:0]  next_idx;
  logic                        oob;
  logic                        issue;
  logic                        finish;

  always_comb begin
    // child index beyond the memory reads as an all-zero node (a leaf)
    node      = oob_q ? '0 : rd_data_i;
    leaf      = (node[hufd_pkg::HalfW-1:0] == '0);
    emit_wait = pend_q && leaf && !emit_ready_i;
    eval      = pend_q && !emit_wait;

    cur_d  = cur_q;
    walk_d = walk_q;
    if (eval) begin
      cur_d  = leaf ? root_q : node;
      walk_d = leaf ? '0 : nidx_q;
    end

    bit_val  = word_q[pos_q];
    next_idx = bit_val ? cur_d[hufd_pkg::NodeW-1:hufd_pkg::HalfW]
                       : cur_d[hufd_pkg::HalfW-1:0];
    oob      = ({16'b0, next_idx} >= 32'(TREE_DEPTH));

    issue  = (state_q == StRun) && (left_q != '0) && !emit_wait;
    finish = (state_q == StRun) && (left_q == '0) && !pend_q && emit_ready_i;
  end

  assign ready_o     = (state_q == StIdle);
  assign rd_en_o     = issue;
  assign rd_addr_o   = oob ? '0 : AddrW'(next_idx);
  assign emit_o.sym_v = eval && leaf;
  assign emit_o.sym   = node[hufd_pkg::HalfW+hufd_pkg::SymW-1:hufd_pkg::HalfW];
  assign emit_o.done  = finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      walk_q  <= '0;
      pend_q  <= 1'b0;
      left_q  <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (cmd_valid_i && cmd_i.load && cmd_i.node_ok) begin
            // keep the cached nodes coherent with the memory
            if (cmd_i.node_index == '0) begin
              root_q <= cmd_i.node;
            end
            if (AddrW'(cmd_i.node_index) == walk_q) begin
              cur_q <= cmd_i.node;
            end
          end
          if (cmd_valid_i && cmd_i.feed) begin
            state_q <= StRun;
            word_q  <= cmd_i.bits_word;
            pos_q   <= cmd_i.first_bit;
            left_q  <= cmd_i.count;
            if (cmd_i.entry_start) begin
              walk_q <= '0;
              cur_q  <= root_q;
            end
          end
        end
        StRun: begin
          walk_q <= walk_d;
          cur_q  <= cur_d;
          if (issue) begin
            pend_q <= 1'b1;
            nidx_q <= AddrW'(next_idx);
            oob_q  <= oob;
            pos_q  <= pos_q + 1'b1;
            left_q <= left_q - 1'b1;
          end else if (eval) begin
            pend_q <= 1'b0;
          end
          if (finish) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hufd_emit.sv
// Symbol stage: holds the newest symbol until it is known whether it is the
// item's last, then moves it to the output register. Depends on hufd_pkg.
`default_nettype none

module hufd_emit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire hufd_pkg::emit_t emit_i,
  output logic                 emit_ready_o,
  hufd_out_if.source           out_o
);

  logic                      hold_v_q;
  logic [hufd_pkg::SymW-1:0] hold_sym_q;
  logic                      out_v_q;
  logic [hufd_pkg::SymW-1:0] out_sym_q;
  logic                      out_last_q;
  logic                      out_free;
  logic                      push_mid;
  logic                      push_last;

  assign out_free     = !out_v_q || out_o.ready;
  assign emit_ready_o = !hold_v_q || out_free;
  assign push_mid     = emit_i.sym_v && hold_v_q;
  assign push_last    = emit_i.done && hold_v_q;

  assign out_o.valid  = out_v_q;
  assign out_o.symbol = out_sym_q;
  assign out_o.last   = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_v_q    <= 1'b1;
        out_sym_q  <= hold_sym_q;
        out_last_q <= push_last;
      end
      if (emit_i.sym_v) begin
        hold_v_q   <= 1'b1;
        hold_sym_q <= emit_i.sym;
      end else if (emit_i.done) begin
        hold_v_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/huffman_tree_decoder.sv
// Huffman tree decoder top level: input decode, node memory, walk sequencer
// and symbol stage. Depends on hufd_pkg, hufd_if, hufd_ram, hufd_walk, hufd_emit.
//
// in_i takes two kinds of item. A load item (op = 0) writes one tree node into
// the node memory and returns nothing. A feed item (op = 1) hands
// over a 16-bit stream word; bits from first_bit upward are decoded LSB first,
// count clipped at bit 15. Each symbol reached goes out on out_o as one item,
// with last set on the final symbol of the feed item.
// A feed item holds in_i not ready from when it is accepted until its word
// is done, so no new item is taken while a word is being decoded. Each bit
// is one dependent read of the node memory, issued in the same cycle that
// the previous read is evaluated. in_i is ready again when the word is done,
// while the last symbols may still sit in the output stage.
// Reset puts the walk at the root; node memory contents are undefined until
// loaded. When out_o stalls, two symbols are buffered and then the walk
// pauses on the next leaf until the output register drains.
`default_nettype none

module huffman_tree_decoder #(
  parameter int TREE_DEPTH = 512
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hufd_in_if.sink    in_i,
  hufd_out_if.source out_o
);

  localparam int AddrW = $clog2(TREE_DEPTH);

  hufd_pkg::cmd_t              cmd;
  hufd_pkg::emit_t             emit;
  logic                        accept;
  logic                        walk_ready;
  logic                        emit_ready;
  logic [hufd_pkg::CntW-1:0]   avail;
  logic                        rd_en;
  logic [AddrW-1:0]            rd_addr;
  logic [hufd_pkg::NodeW-1:0]  rd_data;

  assign in_i.ready = walk_ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    avail            = 5'd16 - {1'b0, in_i.first_bit};
    cmd.load         = accept && (in_i.op == hufd_pkg::OpLoad);
    cmd.feed         = accept && (in_i.op == hufd_pkg::OpFeed);
    cmd.node_index   = in_i.node_index;
    cmd.node_ok      = ({7'b0, in_i.node_index} < 16'(TREE_DEPTH));
    cmd.node         = {in_i.child_one, in_i.child_zero};
    cmd.entry_start  = in_i.entry_start;
    cmd.bits_word    = in_i.bits_word;
    cmd.first_bit    = in_i.first_bit;
    cmd.count        = (in_i.bit_count > avail) ? avail : in_i.bit_count;
  end

  hufd_ram #(
    .Width (hufd_pkg::NodeW),
    .Depth (TREE_DEPTH)
  ) u_nodes (
    .clk_i   (clk_i),
    .we_i    (cmd.load && cmd.node_ok),
    .waddr_i (AddrW'(cmd.node_index)),
    .wdata_i (cmd.node),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  hufd_walk #(
    .TREE_DEPTH (TREE_DEPTH)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (accept),
    .cmd_i        (cmd),
    .ready_o      (walk_ready),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .emit_ready_i (emit_ready),
    .emit_o       (emit)
  );

  hufd_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_i       (emit),
    .emit_ready_o (emit_ready),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire
